// ===== hdl/ifdc_pkg.sv =====
// Package for the I-frame deframer and checker: line codes, verdict codes
// and the result record. No dependencies; used by every file but ifdc_if.sv.
`timescale 1ns / 1ps

package ifdc_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;
    localparam logic [7:0] SEQ_BIT   = 8'h40;
    localparam logic [7:0] CTRL_SEQ0 = 8'h00;

    localparam logic [7:0] ADDR_RESET = 8'h03;

    // Reply control bytes, by the sequence number of the received frame.
    localparam logic [7:0] RR_SEQ0  = 8'h85;
    localparam logic [7:0] RR_SEQ1  = 8'h05;
    localparam logic [7:0] REJ_SEQ0 = 8'h81;
    localparam logic [7:0] REJ_SEQ1 = 8'h01;

    localparam logic       KIND_DATA    = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    localparam logic [1:0] STATUS_NEW   = 2'd0;
    localparam logic [1:0] STATUS_DUP   = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [1:0]  status;
        logic        send_response;
        logic [7:0]  response_ctrl;
        logic [15:0] payload_count;
    } t_result;

endpackage

// ===== hdl/ifdc_if.sv =====
// Valid/ready channel interfaces: received line bytes in, results out.
// Depends on nothing; the field widths repeat those fixed in ifdc_pkg.
`timescale 1ns / 1ps

interface ifdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifdc_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic        send_response;
    logic [7:0]  response_ctrl;
    logic [15:0] payload_count;

    modport source (output valid, output kind, output data_byte, output status,
                    output send_response, output response_ctrl,
                    output payload_count, input ready);
    modport sink   (input valid, input kind, input data_byte, input status,
                    input send_response, input response_ctrl,
                    input payload_count, output ready);
endinterface

// ===== hdl/ifdc_frame_fsm.sv =====
// Frame state machine: flag hunt, header check, destuffing and verdict.
// Depends on ifdc_pkg; instantiated by iframe_deframer_checker.
`timescale 1ns / 1ps

module ifdc_frame_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output ifdc_pkg::t_result o_res
);
    import ifdc_pkg::*;

    localparam logic [2:0] ST_HUNT = 3'd0;
    localparam logic [2:0] ST_FLAG = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_CTRL = 3'd3;
    localparam logic [2:0] ST_HDR  = 3'd4;
    localparam logic [2:0] ST_DATA = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [7:0]  r_addr;
    logic        r_seq_rx, n_seq_rx;
    logic        r_esc, n_esc;
    logic [7:0]  r_held, n_held;
    logic        r_held_v, n_held_v;
    logic [7:0]  r_check, n_check;
    logic [15:0] r_count, n_count;
    logic        r_exp_seq, n_exp_seq;

    // Frame context seen by the payload path; the first payload byte
    // starts from a cleared frame.
    logic        e_esc, e_held_v;
    logic [7:0]  e_held, e_check;
    logic [15:0] e_count;

    logic        dp_take, dp_esc;
    logic [7:0]  dp_val;
    logic [7:0]  hdr_expect;

    always_comb begin
        if (r_state == ST_HDR) begin
            e_esc    = 1'b0;
            e_held   = 8'h00;
            e_held_v = 1'b0;
            e_check  = 8'h00;
            e_count  = 16'd0;
        end else begin
            e_esc    = r_esc;
            e_held   = r_held;
            e_held_v = r_held_v;
            e_check  = r_check;
            e_count  = r_count;
        end
    end

    // Destuffing: an unknown escaped byte is dropped along with its escape.
    always_comb begin
        dp_take = 1'b0;
        dp_esc  = 1'b0;
        dp_val  = i_byte;
        if (e_esc) begin
            if (i_byte == ESC_FLAG) begin
                dp_take = 1'b1;
                dp_val  = FLAG_BYTE;
            end else if (i_byte == ESC_ESC) begin
                dp_take = 1'b1;
                dp_val  = ESC_BYTE;
            end
        end else if (i_byte == ESC_BYTE) begin
            dp_esc = 1'b1;
        end else begin
            dp_take = 1'b1;
        end
    end

    assign hdr_expect = r_addr ^ (r_seq_rx ? SEQ_BIT : CTRL_SEQ0);

    always_comb begin
        n_state     = r_state;
        n_seq_rx    = r_seq_rx;
        n_esc       = r_esc;
        n_held      = r_held;
        n_held_v    = r_held_v;
        n_check     = r_check;
        n_count     = r_count;
        n_exp_seq   = r_exp_seq;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_take) begin
            unique case (r_state)
                ST_FLAG: begin
                    if (i_byte == r_addr) begin
                        n_state = ST_ADDR;
                    end else if (i_byte != FLAG_BYTE) begin
                        n_state = ST_HUNT;
                    end
                end
                ST_ADDR: begin
                    if (i_byte == CTRL_SEQ0 || i_byte == SEQ_BIT) begin
                        n_seq_rx = i_byte[6];
                        n_state  = ST_CTRL;
                    end else if (i_byte == FLAG_BYTE) begin
                        n_state = ST_FLAG;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
                ST_CTRL: begin
                    if (i_byte == hdr_expect) begin
                        n_esc    = 1'b0;
                        n_held   = 8'h00;
                        n_held_v = 1'b0;
                        n_check  = 8'h00;
                        n_count  = 16'd0;
                        n_state  = ST_HDR;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
                ST_HDR, ST_DATA: begin
                    if (i_byte == FLAG_BYTE) begin
                        if (r_state == ST_HDR) begin
                            n_state = ST_FLAG;
                        end else begin
                            o_res_valid   = 1'b1;
                            o_res.kind    = KIND_VERDICT;
                            priority if (!r_held_v) begin
                                o_res.status = STATUS_EMPTY;
                            end else if (r_held == r_check) begin
                                o_res.send_response = 1'b1;
                                o_res.response_ctrl = r_seq_rx ? RR_SEQ1 : RR_SEQ0;
                                o_res.payload_count = r_count;
                                if (r_seq_rx != r_exp_seq) begin
                                    o_res.status = STATUS_DUP;
                                end else begin
                                    o_res.status = STATUS_NEW;
                                    n_exp_seq    = ~r_exp_seq;
                                end
                            end else begin
                                o_res.status        = STATUS_ERROR;
                                o_res.send_response = 1'b1;
                                o_res.response_ctrl = r_seq_rx ? REJ_SEQ1 : REJ_SEQ0;
                                o_res.payload_count = r_count;
                            end
                            n_esc    = 1'b0;
                            n_held   = 8'h00;
                            n_held_v = 1'b0;
                            n_check  = 8'h00;
                            n_count  = 16'd0;
                            n_state  = ST_HUNT;
                        end
                    end else begin
                        n_state  = ST_DATA;
                        n_esc    = dp_esc;
                        n_held   = dp_take ? dp_val : e_held;
                        n_held_v = e_held_v | dp_take;
                        n_check  = e_check;
                        n_count  = e_count;
                        if (dp_take && e_held_v) begin
                            o_res_valid     = 1'b1;
                            o_res.kind      = KIND_DATA;
                            o_res.data_byte = e_held;
                            n_check         = e_check ^ e_held;
                            n_count = (e_count != COUNT_MAX) ? e_count + 16'd1 : e_count;
                        end
                    end
                end
                default: begin
                    n_state = (i_byte == FLAG_BYTE) ? ST_FLAG : ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_HUNT;
            r_addr    <= ADDR_RESET;
            r_seq_rx  <= 1'b0;
            r_esc     <= 1'b0;
            r_held    <= 8'h00;
            r_held_v  <= 1'b0;
            r_check   <= 8'h00;
            r_count   <= 16'd0;
            r_exp_seq <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= i_cfg_we ? i_cfg_data : r_addr;
            r_seq_rx  <= n_seq_rx;
            r_esc     <= n_esc;
            r_held    <= n_held;
            r_held_v  <= n_held_v;
            r_check   <= n_check;
            r_count   <= n_count;
            r_exp_seq <= n_exp_seq;
        end
    end

endmodule

// ===== hdl/iframe_deframer_checker.sv =====
// Top level of the I-frame deframer and checker: frame state machine plus
// a two-entry result buffer. Depends on ifdc_pkg, ifdc_if.sv, ifdc_frame_fsm.
//
//   Channel   Direction  Handshake     Payload
//   i_rx      in         valid/ready   rx_byte (8)
//   o_res     out        valid/ready   kind, data_byte, status, send_response,
//                                      response_ctrl, payload_count
//   cfg       in         i_cfg_we      i_cfg_data: address byte (reset 0x03)
//
// One received byte is taken in every cycle while the buffer has room; the state
// machine works on it in the cycle of the transaction and any result it causes
// is written into the result buffer, which drives o_res.
// The two-entry result buffer lets input keep flowing while a result waits;
// i_rx.ready drops only when both entries are full, so a stalled consumer
// holds off the line after two waiting results.
// Reset is synchronous and active low: the state machine returns to flag hunt,
// the expected sequence number to zero, the address to 0x03, the buffer empties.
`timescale 1ns / 1ps

module iframe_deframer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    ifdc_in_if.sink     i_rx,
    ifdc_res_if.source  o_res
);
    import ifdc_pkg::*;

    logic    take;
    logic    push;
    logic    pop;
    t_result res;

    // Result buffer: two entries with read and write pointers and a fill count.
    t_result    r_buf [0:1];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;
    t_result    head;

    assign i_rx.ready = (r_fill != 2'd2);
    assign take       = i_rx.valid && i_rx.ready;

    ifdc_frame_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (push),
        .o_res       (res)
    );

    // Only a transaction can push, and it is refused when the buffer is
    // full, so a push never overwrites a waiting result.
    assign pop = o_res.valid && o_res.ready;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 2'd1;
        end else if (pop && !push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Buffer entries carry payload only and need no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= res;
        end
    end

    assign head = r_buf[r_rd_ptr];

    assign o_res.valid         = (r_fill != 2'd0);
    assign o_res.kind          = head.kind;
    assign o_res.data_byte     = head.data_byte;
    assign o_res.status        = head.status;
    assign o_res.send_response = head.send_response;
    assign o_res.response_ctrl = head.response_ctrl;
    assign o_res.payload_count = head.payload_count;

endmodule

// ===== hdl/ifdc_checker.sv =====
// Port-level assertions for iframe_deframer_checker, attached by bind.
// Depends on ifdc_pkg and on the channel interfaces of the top level.
`timescale 1ns / 1ps

module ifdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_kind,
    input logic [7:0]  i_data_byte,
    input logic [1:0]  i_status,
    input logic        i_send_response,
    input logic [7:0]  i_response_ctrl,
    input logic [15:0] i_payload_count
);
    import ifdc_pkg::*;

    // A waiting result keeps its kind, data, status, reply code and count until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_data_byte) && $stable(i_status)
            && $stable(i_response_ctrl) && $stable(i_payload_count))
        else $error("result changed while stalled");

    // Reset empties the result buffer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Input is refused only when results are waiting.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no waiting result");

    // The reply code matches the verdict.
    a_reply_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_VERDICT |->
            ((i_status == STATUS_EMPTY && !i_send_response
                && i_response_ctrl == 8'h00 && i_payload_count == 16'd0)
          || ((i_status == STATUS_NEW || i_status == STATUS_DUP) && i_send_response
                && (i_response_ctrl == RR_SEQ0 || i_response_ctrl == RR_SEQ1))
          || (i_status == STATUS_ERROR && i_send_response
                && (i_response_ctrl == REJ_SEQ0 || i_response_ctrl == REJ_SEQ1))))
        else $error("reply code does not match verdict");

endmodule

bind iframe_deframer_checker ifdc_checker u_ifdc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_rx.valid),
    .i_in_ready      (i_rx.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_kind          (o_res.kind),
    .i_data_byte     (o_res.data_byte),
    .i_status        (o_res.status),
    .i_send_response (o_res.send_response),
    .i_response_ctrl (o_res.response_ctrl),
    .i_payload_count (o_res.payload_count)
);

// ===== test/iframe_deframer_checker_tb.sv =====
// Self-checking testbench for iframe_deframer_checker: byte-level stimulus, an in-bench
// deframer that predicts every payload byte and verdict, random idling on both channels.
// Depends on ifdc_pkg and the channel interfaces in hdl/ifdc_if.sv.
`timescale 1ns / 1ps

import ifdc_pkg::*;

// Scoreboard: mirrors the deframer state for every accepted line byte and keeps the
// results that this must produce, in order, until the block delivers them.
class frame_scoreboard;
    typedef enum logic [2:0] {
        FS_HUNT, FS_FLAG, FS_ADDR, FS_CTRL, FS_HDR, FS_DATA
    } t_frame_phase;

    t_result      expected_results[$];
    int           errors;
    int           payload_seen;
    int           verdict_tally[4];

    logic [7:0]   address;
    t_frame_phase phase;
    logic         seq_rx;
    logic         esc_pending;
    logic         held_valid;
    logic [7:0]   held_byte;
    logic [7:0]   running_check;
    logic [15:0]  byte_count;
    logic         exp_seq;

    function new();
        address = ADDR_RESET;
        phase   = FS_HUNT;
        seq_rx  = 1'b0;
        exp_seq = 1'b0;
        clear_frame();
    endfunction

    function void set_address(logic [7:0] a);
        address = a;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function logic next_seq();
        return exp_seq;
    endfunction

    function void clear_frame();
        esc_pending   = 1'b0;
        held_byte     = '0;
        held_valid    = 1'b0;
        running_check = '0;
        byte_count    = '0;
    endfunction

    // A destuffed byte releases the one held before it, since the last is the check.
    function void take_payload(logic [7:0] d);
        t_result r;
        if (held_valid) begin
            r = '0;
            r.kind = KIND_DATA;
            r.data_byte = held_byte;
            expected_results.push_back(r);
            running_check = running_check ^ held_byte;
            if (byte_count != COUNT_MAX) begin
                byte_count = byte_count + 16'd1;
            end
        end
        held_byte  = d;
        held_valid = 1'b1;
    endfunction

    function void destuff(logic [7:0] b);
        if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == ESC_FLAG) begin
                take_payload(FLAG_BYTE);
            end else if (b == ESC_ESC) begin
                take_payload(ESC_BYTE);
            end
        end else if (b == ESC_BYTE) begin
            esc_pending = 1'b1;
        end else begin
            take_payload(b);
        end
    endfunction

    function void push_verdict();
        t_result r;
        r = '0;
        r.kind = KIND_VERDICT;
        if (!held_valid) begin
            r.status = STATUS_EMPTY;
        end else if (held_byte == running_check) begin
            r.send_response = 1'b1;
            r.response_ctrl = seq_rx ? RR_SEQ1 : RR_SEQ0;
            r.payload_count = byte_count;
            if (seq_rx != exp_seq) begin
                r.status = STATUS_DUP;
            end else begin
                r.status = STATUS_NEW;
                exp_seq  = ~exp_seq;
            end
        end else begin
            r.status        = STATUS_ERROR;
            r.send_response = 1'b1;
            r.response_ctrl = seq_rx ? REJ_SEQ1 : REJ_SEQ0;
            r.payload_count = byte_count;
        end
        expected_results.push_back(r);
    endfunction

    function void note_rx_byte(logic [7:0] b);
        case (phase)
            FS_FLAG: begin
                if (b == address) begin
                    phase = FS_ADDR;
                end else if (b != FLAG_BYTE) begin
                    phase = FS_HUNT;
                end
            end
            FS_ADDR: begin
                if (b == CTRL_SEQ0 || b == SEQ_BIT) begin
                    seq_rx = b[6];
                    phase  = FS_CTRL;
                end else if (b == FLAG_BYTE) begin
                    phase = FS_FLAG;
                end else begin
                    phase = FS_HUNT;
                end
            end
            FS_CTRL: begin
                if (b == (address ^ (seq_rx ? SEQ_BIT : CTRL_SEQ0))) begin
                    clear_frame();
                    phase = FS_HDR;
                end else begin
                    phase = FS_HUNT;
                end
            end
            FS_HDR: begin
                if (b == FLAG_BYTE) begin
                    phase = FS_FLAG;
                end else begin
                    clear_frame();
                    phase = FS_DATA;
                    destuff(b);
                end
            end
            FS_DATA: begin
                if (b == FLAG_BYTE) begin
                    push_verdict();
                    clear_frame();
                    phase = FS_HUNT;
                end else begin
                    destuff(b);
                end
            end
            default: begin
                phase = (b == FLAG_BYTE) ? FS_FLAG : FS_HUNT;
            end
        endcase
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    task check_result(t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            report($sformatf("result with nothing expected: kind %0d data %h status %0d",
                             got.kind, got.data_byte, got.status));
        end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.data_byte !== want.data_byte)
                report($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.send_response !== want.send_response)
                report($sformatf("send_response %0d, expected %0d",
                                 got.send_response, want.send_response));
            if (got.response_ctrl !== want.response_ctrl)
                report($sformatf("response_ctrl %h, expected %h",
                                 got.response_ctrl, want.response_ctrl));
            if (got.payload_count !== want.payload_count)
                report($sformatf("payload_count %0d, expected %0d",
                                 got.payload_count, want.payload_count));
            if (want.kind == KIND_DATA) begin
                payload_seen++;
            end else begin
                verdict_tally[want.status]++;
            end
        end
    endtask
endclass

module iframe_deframer_checker_tb;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    // The slowest correct run never goes this long without a transaction or a
    // register write; only a hung block does.
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_BYTES  = 550;
    localparam int NUM_PHASES    = 6;
    // The last byte is noted by the monitor at its own edge, and its result is
    // written into the buffer at that same edge; these cycles cover both.
    localparam int SETTLE_CYCLES = 4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_data;

    ifdc_in_if  rx_ch ();
    ifdc_res_if res_ch ();

    frame_scoreboard sb;

    int          gap_pct     = 0;
    int          stall_pct   = 0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    logic [7:0]  cur_addr;

    // The directed opening, with the reset address 0x03:
    //   flag, flag, address: a flag while waiting for the address keeps waiting;
    //   flag: a flag while waiting for the control byte restarts the frame;
    //   03 40 43: header with sequence one;
    //   7D 5E gives 0x7E; 7D 33 is an unknown escape; 7D 7D drops both bytes;
    //   closing flag: the lone 0x7E fails the data check, so REJ is expected;
    //   then a frame whose payload is a pending escape only, which is empty;
    //   then a good frame of 00 FF FF with check byte 00, taken as new.
    logic [7:0] directed_seq [29] = '{
        8'h7E, 8'h7E, 8'h03, 8'h7E, 8'h03, 8'h40, 8'h43,
        8'h7D, 8'h5E, 8'h7D, 8'h33, 8'h7D, 8'h7D, 8'h7E,
        8'h7E, 8'h03, 8'h00, 8'h03, 8'h7D, 8'h7E,
        8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h7E
    };

    // Address used in each phase; the first runs with the reset value and the
    // fifth draws a random one.
    logic [7:0] phase_addr [NUM_PHASES] = '{
        ADDR_RESET, 8'h00, 8'hFF, FLAG_BYTE, 8'h00, ADDR_RESET
    };

    iframe_deframer_checker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_ch),
        .o_res      (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // The consumer stalls at random according to the current phase.
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Monitor. Signals are sampled at the rising edge, before this edge's
    // nonblocking updates, so each handshake is seen exactly as the block saw it.
    // The result is checked before the byte of the same edge is noted; a byte
    // cannot cause a result in its own cycle.
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.kind          = res_ch.kind;
                got.data_byte     = res_ch.data_byte;
                got.status        = res_ch.status;
                got.send_response = res_ch.send_response;
                got.response_ctrl = res_ch.response_ctrl;
                got.payload_count = res_ch.payload_count;
                sb.check_result(got);
            end
            if (rx_ch.valid && rx_ch.ready) begin
                sb.note_rx_byte(rx_ch.rx_byte);
            end
            if ((res_ch.valid && res_ch.ready) || (rx_ch.valid && rx_ch.ready) || i_cfg_we) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Watchdog: a long stretch with no transaction at all means the block hung.
    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Watchdog expired after %0d cycles without a transaction", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Offers one line byte, with random idle cycles ahead of it when the phase
    // asks for them, and returns at the edge where the transaction takes place.
    // Valid stays high into the next call so back-to-back bytes need no gap.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < gap_pct) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Sends a payload byte, stuffed where it collides with the flag or escape.
    task automatic send_data(input logic [7:0] d);
        if (d == FLAG_BYTE || d == ESC_BYTE) begin
            send_byte(ESC_BYTE);
            send_byte((d == FLAG_BYTE) ? ESC_FLAG : ESC_ESC);
        end else begin
            send_byte(d);
        end
    endtask

    // A well-formed frame with random payload. A bad check flips some bits of the
    // check byte; junk escapes add escape pairs with a random second byte and sometimes
    // leave an escape pending at the closing flag.
    task automatic send_frame(input int len, input logic seq, input bit good_check,
                              input bit with_check, input bit junk_escapes);
        logic [7:0] ctrl;
        logic [7:0] chk;
        logic [7:0] d;
        ctrl = seq ? SEQ_BIT : CTRL_SEQ0;
        chk  = '0;
        send_byte(FLAG_BYTE);
        send_byte(cur_addr);
        send_byte(ctrl);
        send_byte(cur_addr ^ ctrl);
        for (int i = 0; i < len; i++) begin
            d = 8'($urandom_range(0, 255));
            chk ^= d;
            send_data(d);
            if (junk_escapes && $urandom_range(0, 5) == 0) begin
                // A flag after an escape would close the frame, so it is avoided here.
                d = 8'($urandom_range(0, 255));
                send_byte(ESC_BYTE);
                send_byte((d == FLAG_BYTE) ? 8'h00 : d);
            end
        end
        if (with_check) begin
            send_data(good_check ? chk : chk ^ 8'($urandom_range(1, 255)));
        end
        if (junk_escapes && $urandom_range(0, 3) == 0) begin
            send_byte(ESC_BYTE);
        end
        send_byte(FLAG_BYTE);
    endtask

    // One random burst: mostly good frames, some damaged headers, some line noise.
    task automatic send_random_burst();
        int         pick;
        int         len;
        logic       seq;
        logic [7:0] ctrl;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            // Mostly the sequence the block waits for, so frames are new; the rest use a random sequence.
            seq = ($urandom_range(0, 9) < 7) ? sb.next_seq() : 1'($urandom_range(0, 1));
            send_frame(len, seq, $urandom_range(0, 9) < 8, len > 0 || $urandom_range(0, 1),
                       $urandom_range(0, 4) == 0);
        end else if (pick < 88) begin
            ctrl = $urandom_range(0, 1) ? SEQ_BIT : CTRL_SEQ0;
            send_byte(FLAG_BYTE);
            case ($urandom_range(0, 3))
                0: begin
                    send_byte(cur_addr ^ (8'h01 << $urandom_range(0, 7)));
                end
                1: begin
                    send_byte(cur_addr);
                    send_byte(ctrl | (8'h01 << $urandom_range(0, 5)));
                end
                2: begin
                    send_byte(cur_addr);
                    send_byte(ctrl);
                    send_byte(cur_addr ^ ctrl ^ (8'h01 << $urandom_range(0, 7)));
                end
                default: begin
                    // Flag straight after the header: no verdict, it opens again.
                    send_byte(cur_addr);
                    send_byte(ctrl);
                    send_byte(cur_addr ^ ctrl);
                    send_byte(FLAG_BYTE);
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 3))
                    0:       b = FLAG_BYTE;
                    1:       b = ESC_BYTE;
                    2:       b = cur_addr;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b);
            end
        end
    endtask

    // Holds the sender off, lets the last byte be noted and its result reach the
    // buffer, then waits until every expected result has arrived.
    task automatic settle();
        rx_ch.valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [7:0] a);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= a;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_addr = a;
        sb.set_address(a);
    endtask

    initial begin : stimulus
        sb = new();
        cur_addr = ADDR_RESET;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_seq[i]) begin
            send_byte(directed_seq[i]);
        end

        // Each phase has its own address and idle pattern: none, sender gaps,
        // consumer stalls, then both. The block is drained before every write.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                settle();
                write_address((p == 4) ? 8'($urandom_range(0, 255)) : phase_addr[p]);
            end
            case (p % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 46; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 46; end
                default: begin gap_pct = 37; stall_pct = 37; end
            endcase
            begin : phase_body
                int start;
                start = bytes_sent;
                while (bytes_sent - start < RANDOM_BYTES / NUM_PHASES) begin
                    send_random_burst();
                end
            end
        end

        settle();

        $display("Run covered %0d line bytes over %0d address settings and four idle patterns,",
                 bytes_sent, NUM_PHASES);
        $display("checking %0d payload bytes and verdicts new %0d, dup %0d, error %0d, empty %0d.",
                 sb.payload_seen, sb.verdict_tally[STATUS_NEW], sb.verdict_tally[STATUS_DUP],
                 sb.verdict_tally[STATUS_ERROR], sb.verdict_tally[STATUS_EMPTY]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
